/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define ASSERT_CLK_RSTN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/adbe_pkg.sv */
// Package for the audio DMA block engine: constants, codes and payload structs.
// No dependencies; used by the engine and its checker.
package adbe_pkg;

    // Fetch size and size of main memory in bytes.
    localparam int unsigned BLOCK_BYTES  = 32;
    localparam int unsigned MEMORY_LIMIT = 25165824;
    localparam int unsigned OFF_W        = 25;
    localparam int unsigned CMP_W        = OFF_W + 1;

    // Register indexes.
    localparam logic [2:0] IDX_SRC_HI  = 3'd0;
    localparam logic [2:0] IDX_SRC_LO  = 3'd1;
    localparam logic [2:0] IDX_CONTROL = 3'd3;
    localparam logic [2:0] IDX_LEFT    = 3'd5;
    localparam logic [2:0] IDX_LAST    = 3'd7;

    // Control register layout.
    localparam int unsigned CTRL_EN_BIT = 15;

    // Operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_READ_ONLY  = 2'd1;
    localparam logic [1:0] ERR_RANGE      = 2'd2;
    localparam logic [1:0] ERR_WORD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  reg_index;
        logic        access_size;
        logic [31:0] write_data;
    } adbe_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        block_valid;
        logic [31:0] block_address;
        logic        irq;
        logic [1:0]  error_code;
    } adbe_out_t;

endpackage

/* hw/rtl/audio_dma_block_engine.sv */
// Audio DMA block engine: register file, block address generator and result register.
// Depends on adbe_pkg.
//
//  Channel | Ports                        | Carries
//  --------+------------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data     | read, write or tick transaction
//  result  | m_valid, m_ready, m_data     | one result per input transaction
//
// Each transaction passes through the input register and then the result register,
// and one transaction is taken every cycle while the result channel is not stalled.
// The register update and the address adder/compare sit between those two registers.
// Reset clears the register file, the address, the count and both valid flags.
// A stalled result stops the input register, and s_ready drops only when both are full.
module audio_dma_block_engine
    import adbe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  adbe_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output adbe_out_t m_data
);

    logic             in_valid_reg;
    adbe_in_t         in_data_reg;
    logic             out_valid_reg;
    adbe_out_t        out_data_reg;
    logic [15:0]      regfile_reg [8];
    logic [15:0]      regfile_next [8];
    logic [31:0]      addr_reg;
    logic [31:0]      addr_next;
    logic [14:0]      rem_reg;
    logic [14:0]      rem_next;
    logic             advance;
    logic             fire;
    adbe_out_t        result;

    // The input register moves on when the result register is free or being emptied.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Register access and tick processing for the transaction in the input register.
    always_comb begin
        logic [2:0]  idx;
        logic [2:0]  idx_lo;
        logic        word;
        logic        word_bad;
        logic [14:0] left_val;
        logic [15:0] rd_hi;
        logic [15:0] rd_lo;
        logic [7:0]  we;
        logic [15:0] wv [8];
        logic        enabled;
        logic [CMP_W-1:0] end_off;

        idx      = in_data_reg.reg_index;
        idx_lo   = idx + 3'd1;
        word     = in_data_reg.access_size;
        word_bad = word && (idx == IDX_LAST);
        left_val = (rem_reg == 15'd0) ? 15'd0 : rem_reg - 15'd1;
        rd_hi    = (idx == IDX_LEFT) ? {1'b0, left_val} : regfile_reg[idx];
        rd_lo    = (idx_lo == IDX_LEFT) ? {1'b0, left_val} : regfile_reg[idx_lo];
        enabled  = regfile_reg[IDX_CONTROL][CTRL_EN_BIT];
        end_off  = {1'b0, addr_reg[OFF_W-1:0]} + CMP_W'(BLOCK_BYTES);

        regfile_next = regfile_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        result       = '0;

        // Halfword write strobes: a word write puts the high half at the index.
        for (int k = 0; k < 8; k++) begin
            we[k] = 1'b0;
            wv[k] = in_data_reg.write_data[15:0];
            if (word) begin
                if (idx == 3'(k)) begin
                    we[k] = 1'b1;
                    wv[k] = in_data_reg.write_data[31:16];
                end else if (idx_lo == 3'(k)) begin
                    we[k] = 1'b1;
                end
            end else if (idx == 3'(k)) begin
                we[k] = 1'b1;
            end
        end

        case (in_data_reg.operation)
            OP_READ: begin
                if (word_bad) begin
                    result.error_code = ERR_WORD_INDEX;
                end else if (word) begin
                    result.read_data = {rd_hi, rd_lo};
                end else begin
                    result.read_data = {16'd0, rd_hi};
                end
            end
            OP_WRITE: begin
                if (word_bad) begin
                    result.error_code = ERR_WORD_INDEX;
                end else begin
                    for (int k = 0; k < 8; k++) begin
                        if (we[k] && (3'(k) != IDX_LEFT)) begin
                            regfile_next[k] = wv[k];
                        end
                    end
                    if (we[IDX_LEFT]) begin
                        result.error_code = ERR_READ_ONLY;
                    end
                    // Rising enable latches the source address and the block count.
                    if (we[IDX_CONTROL] && !enabled && wv[IDX_CONTROL][CTRL_EN_BIT]) begin
                        addr_next = {regfile_reg[IDX_SRC_HI], regfile_reg[IDX_SRC_LO]};
                        rem_next  = wv[IDX_CONTROL][14:0];
                    end
                end
            end
            OP_TICK: begin
                if (enabled) begin
                    result.block_valid   = 1'b1;
                    result.block_address = addr_reg;
                    if (end_off > CMP_W'(MEMORY_LIMIT)) begin
                        result.error_code = ERR_RANGE;
                    end
                    // Last block (or a zero count) re-arms from the registers.
                    if (rem_reg <= 15'd1) begin
                        addr_next  = {regfile_reg[IDX_SRC_HI], regfile_reg[IDX_SRC_LO]};
                        rem_next   = regfile_reg[IDX_CONTROL][14:0];
                        result.irq = 1'b1;
                    end else begin
                        addr_next = addr_reg + 32'(BLOCK_BYTES);
                        rem_next  = rem_reg - 15'd1;
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // Input register, engine state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            rem_reg       <= '0;
            for (int k = 0; k < 8; k++) begin
                regfile_reg[k] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
                in_data_reg  <= s_data;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                out_data_reg  <= result;
            end
            if (fire) begin
                regfile_reg <= regfile_next;
                addr_reg    <= addr_next;
                rem_reg     <= rem_next;
            end
        end
    end

endmodule

/* hw/rtl/adbe_checker.sv */
// Port-level checker for the audio DMA block engine, bound to the top level.
// Depends on adbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adbe_checker
    import adbe_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input adbe_out_t m_data
);

    // A stalled result transaction stays put.
    `ASSERT_CLK_RSTN(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `ASSERT_CLK_RSTN(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result changed while stalled")

    // Fetch fields appear only with an issued block.
    `ASSERT_CLK_RSTN(a_addr_idle, aclk, aresetn, m_valid && !m_data.block_valid |-> m_data.block_address == 32'd0, "address without fetch")
    `ASSERT_CLK_RSTN(a_irq_fetch, aclk, aresetn, m_valid && m_data.irq |-> m_data.block_valid && m_data.read_data == 32'd0, "interrupt without fetch")
    `ASSERT_CLK_RSTN(a_range_fetch, aclk, aresetn, m_valid && m_data.error_code == ERR_RANGE |-> m_data.block_valid, "range error without fetch")

endmodule

bind audio_dma_block_engine adbe_checker u_adbe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/audio_dma_block_engine_tb.sv */
// Self-checking testbench for the audio DMA block engine: register reads and writes, block ticks.
// Predicts every result from a shadow copy of the engine state and checks each result transaction.
// Depends on adbe_pkg and audio_dma_block_engine.
`timescale 1ns / 1ps

module audio_dma_block_engine_tb;
    import adbe_pkg::*;

    // Codes and indexes the package does not name.
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [2:0]  IDX_SPARE_A = 3'd2;
    localparam logic [2:0]  IDX_SPARE_B = 3'd4;
    localparam logic [2:0]  IDX_SPARE_C = 3'd6;
    localparam logic        SIZE_HALF   = 1'b0;
    localparam logic        SIZE_WORD   = 1'b1;
    localparam logic [31:0] ADDR_MASK   = 32'h01FF_FFFF;
    localparam int unsigned RANDOM_ITEMS = 1650;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    adbe_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    adbe_out_t m_data;

    // Stimulus waiting to be driven and results waiting to arrive.
    adbe_in_t  queued_requests[$];
    adbe_out_t pending_responses[$];
    adbe_out_t expected_head;
    int unsigned mismatch_count = 0;
    int unsigned stim_count = 0;

    // Shadow copy of the engine state.
    logic [15:0] reg_shadow [8] = '{default: 16'd0};
    logic [31:0] fetch_addr  = 32'd0;
    logic [14:0] blocks_left = 15'd0;

    // Driver and receiver pacing.
    logic        req_taken  = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned rx_mode    = 0;
    int unsigned rx_left    = 0;
    logic [31:0] rx_cycle   = 32'd0;

    audio_dma_block_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // One halfword register as a read sees it.
    function automatic logic [15:0] shadow_read(input logic [2:0] idx);
        if (idx == IDX_LEFT) begin
            return (blocks_left != 15'd0) ? {1'b0, 15'(blocks_left - 15'd1)} : 16'd0;
        end
        return reg_shadow[idx];
    endfunction

    // One halfword register write; returns 1 when it hit the read-only register.
    function automatic bit shadow_write(input logic [2:0] idx, input logic [15:0] value);
        if (idx == IDX_LEFT) begin
            return 1'b1;
        end
        // Turning enable on latches the source address and the block count.
        if (idx == IDX_CONTROL && !reg_shadow[IDX_CONTROL][CTRL_EN_BIT] && value[CTRL_EN_BIT]) begin
            fetch_addr  = {reg_shadow[IDX_SRC_HI], reg_shadow[IDX_SRC_LO]};
            blocks_left = value[14:0];
        end
        reg_shadow[idx] = value;
        return 1'b0;
    endfunction

    // Expected result of one transaction; updates the shadow state.
    function automatic adbe_out_t dma_response(input adbe_in_t req);
        adbe_out_t   rsp;
        bit          hi_hit;
        bit          lo_hit;
        logic [2:0]  next_idx;
        logic [32:0] span;
        rsp = '0;
        next_idx = 3'(req.reg_index + 3'd1);
        case (req.operation)
            OP_READ, OP_WRITE: begin
                if (req.access_size == SIZE_WORD && req.reg_index == IDX_LAST) begin
                    rsp.error_code = ERR_WORD_INDEX;
                end else if (req.operation == OP_READ) begin
                    if (req.access_size == SIZE_WORD) begin
                        rsp.read_data = {shadow_read(req.reg_index), shadow_read(next_idx)};
                    end else begin
                        rsp.read_data = {16'd0, shadow_read(req.reg_index)};
                    end
                end else begin
                    // A word write goes high half first.
                    if (req.access_size == SIZE_WORD) begin
                        hi_hit = shadow_write(req.reg_index, req.write_data[31:16]);
                        lo_hit = shadow_write(next_idx, req.write_data[15:0]);
                    end else begin
                        hi_hit = shadow_write(req.reg_index, req.write_data[15:0]);
                        lo_hit = 1'b0;
                    end
                    if (hi_hit || lo_hit) begin
                        rsp.error_code = ERR_READ_ONLY;
                    end
                end
            end
            OP_TICK: begin
                if (reg_shadow[IDX_CONTROL][CTRL_EN_BIT]) begin
                    rsp.block_valid   = 1'b1;
                    rsp.block_address = fetch_addr;
                    span = 33'(fetch_addr & ADDR_MASK) + 33'(BLOCK_BYTES);
                    if (span > 33'(MEMORY_LIMIT)) begin
                        rsp.error_code = ERR_RANGE;
                    end
                    if (blocks_left != 15'd0) begin
                        blocks_left = blocks_left - 15'd1;
                        fetch_addr  = fetch_addr + 32'(BLOCK_BYTES);
                    end
                    // Count exhausted: re-arm from the registers.
                    if (blocks_left == 15'd0) begin
                        fetch_addr  = {reg_shadow[IDX_SRC_HI], reg_shadow[IDX_SRC_LO]};
                        blocks_left = reg_shadow[IDX_CONTROL][14:0];
                        rsp.irq     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [2:0] idx,
                                input logic size, input logic [31:0] data);
        adbe_in_t req;
        req.operation   = op;
        req.reg_index   = idx;
        req.access_size = size;
        req.write_data  = data;
        queued_requests.push_back(req);
        if (op != OP_UNUSED) begin
            stim_count++;
        end
    endtask

    // A run of ticks with an occasional register read mixed in.
    task automatic push_ticks(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            push_request(OP_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom);
            if ($urandom_range(0, 4) == 0) begin
                push_request(OP_READ, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             $urandom);
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Record each accepted input transaction and predict its result.
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pending_responses.push_back(dma_response(s_data));
        end
    end

    // Check each accepted result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                expected_head = pending_responses.pop_front();
                compare_field("read_data", expected_head.read_data, m_data.read_data);
                compare_field("block_valid", 32'(expected_head.block_valid),
                              32'(m_data.block_valid));
                compare_field("block_address", expected_head.block_address,
                              m_data.block_address);
                compare_field("irq", 32'(expected_head.irq), 32'(m_data.irq));
                compare_field("error_code", 32'(expected_head.error_code),
                              32'(m_data.error_code));
            end
        end
    end

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (queued_requests.size() != 0) begin
                s_data  <= queued_requests.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that switches between modes.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_cycle <= rx_cycle + 32'd1;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (rx_cycle[1:0] == 2'd0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Stimulus, reset and end of test.
    initial begin
        int unsigned random_goal;
        int unsigned kind;
        logic [31:0] src;
        logic [14:0] count;
        int unsigned ticks;

        // Reset values of every register, then a word read and a word write at the bad word index.
        for (int i = 0; i < 8; i++) begin
            push_request(OP_READ, 3'(i), SIZE_HALF, 32'd0);
        end
        push_request(OP_READ, IDX_LAST, SIZE_WORD, 32'd0);
        push_request(OP_WRITE, IDX_LAST, SIZE_WORD, 32'hFFFF_FFFF);
        // Writes to the read-only register, alone and as the low half of a word.
        push_request(OP_WRITE, IDX_LEFT, SIZE_HALF, 32'hFFFF_FFFF);
        push_request(OP_WRITE, IDX_SPARE_B, SIZE_WORD, 32'hA5A5_5A5A);
        // Source just below the memory limit: the second fetch is out of range.
        push_request(OP_WRITE, IDX_SRC_HI, SIZE_WORD, MEMORY_LIMIT - 2 * BLOCK_BYTES + 32);
        push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF, 32'h0000_8002);
        push_request(OP_TICK, 3'd0, SIZE_HALF, 32'd0);
        push_request(OP_READ, IDX_SPARE_B, SIZE_WORD, 32'd0);
        push_request(OP_TICK, 3'd0, SIZE_HALF, 32'd0);
        // Disabled tick, then a zero count that re-arms on every tick.
        push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF, 32'h0000_0000);
        push_request(OP_TICK, IDX_LAST, SIZE_WORD, 32'hFFFF_FFFF);
        push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF, 32'hFFFF_8000);
        push_ticks(2);
        // Source at the top of the address space wraps around to zero.
        push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF, 32'h0000_7FFF);
        push_request(OP_WRITE, IDX_SRC_HI, SIZE_WORD, 32'hFFFF_FFE0);
        push_request(OP_WRITE, IDX_SPARE_A, SIZE_WORD, 32'hFFFF_8003);
        push_request(OP_TICK, 3'd0, SIZE_HALF, 32'd0);
        push_request(OP_TICK, 3'd0, SIZE_HALF, 32'd0);
        push_request(OP_UNUSED, IDX_LAST, SIZE_WORD, 32'hFFFF_FFFF);
        push_request(OP_WRITE, IDX_LAST, SIZE_HALF, 32'hFFFF_FFFF);
        push_request(OP_READ, IDX_SPARE_C, SIZE_WORD, 32'd0);

        // Random part: mostly well-formed programming sequences, then ticks and noise.
        random_goal = stim_count + RANDOM_ITEMS;
        while (stim_count < random_goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                case ($urandom_range(0, 4))
                    0: src = $urandom;
                    1: src = {7'($urandom_range(0, 127)),
                              25'(MEMORY_LIMIT - $urandom_range(0, 8 * BLOCK_BYTES))};
                    2: src = {7'($urandom_range(0, 127)),
                              25'(ADDR_MASK - $urandom_range(0, 8 * BLOCK_BYTES))};
                    3: src = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    default: src = $urandom_range(0, 4095);
                endcase
                // Source address as one word or as two halfwords in either order.
                if ($urandom_range(0, 1) == 0) begin
                    push_request(OP_WRITE, IDX_SRC_HI, SIZE_WORD, src);
                end else if ($urandom_range(0, 1) == 0) begin
                    push_request(OP_WRITE, IDX_SRC_HI, SIZE_HALF, {16'($urandom), src[31:16]});
                    push_request(OP_WRITE, IDX_SRC_LO, SIZE_HALF, {16'($urandom), src[15:0]});
                end else begin
                    push_request(OP_WRITE, IDX_SRC_LO, SIZE_HALF, {16'($urandom), src[15:0]});
                    push_request(OP_WRITE, IDX_SRC_HI, SIZE_HALF, {16'($urandom), src[31:16]});
                end
                // Usually disable first so that the enable is a fresh rising edge.
                if ($urandom_range(0, 7) != 0) begin
                    push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF,
                                 {16'($urandom), 1'b0, 15'($urandom)});
                end
                count = ($urandom_range(0, 3) != 0) ? 15'($urandom_range(0, 6))
                                                    : 15'($urandom);
                case ($urandom_range(0, 2))
                    0: push_request(OP_WRITE, IDX_CONTROL, SIZE_HALF,
                                    {16'($urandom), 1'b1, count});
                    1: push_request(OP_WRITE, IDX_SPARE_A, SIZE_WORD,
                                    {16'($urandom), 1'b1, count});
                    default: push_request(OP_WRITE, IDX_CONTROL, SIZE_WORD,
                                          {1'b1, count, 16'($urandom)});
                endcase
                if (count <= 15'd6) begin
                    ticks = (int'(count) + 1) * $urandom_range(1, 3) + $urandom_range(0, 2);
                end else begin
                    ticks = $urandom_range(1, 20);
                end
                push_ticks((ticks > 40) ? 40 : ticks);
            end else if (kind < 85) begin
                push_ticks($urandom_range(1, 10));
            end else begin
                push_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), $urandom);
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain all stimulus and results, then let the pipeline settle.
        while (queued_requests.size() != 0 || s_valid || pending_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("audio_dma_block_engine test passed");
        end else begin
            $display("audio_dma_block_engine test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("audio_dma_block_engine test failed");
        $finish;
    end

endmodule
